// ===== sv/rscr_pkg.sv =====
// ----------------------------------------------------------------------------
// rscr_pkg: shared types and constants for the random subset CV router
// Field types, register indexes and the xorshift32 generator step.
// ----------------------------------------------------------------------------
package rscr_pkg;

  // Sample and register field types.
  typedef logic signed [15:0] level_t;
  typedef logic [3:0]         count_t;
  typedef logic [8:0]         chance_t;
  typedef logic [7:0]         mask_t;
  typedef logic [31:0]        word_t;
  typedef logic [1:0]         cfg_idx_t;

  // Width of the output mask fields.
  localparam int MASK_W = 8;

  // Width that holds a saturated channel count of up to 16.
  localparam int CNT_W = 5;

  // Largest chance value; it means every eligible channel.
  localparam chance_t CHANCE_MAX = 9'd256;

  // Reset values of the configuration registers.
  localparam level_t TRIG_ON_RST  = 16'sd2048;
  localparam level_t TRIG_OFF_RST = 16'sd0;
  localparam word_t  SEED_RST     = 32'd1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TRIG_ON  = 2'd0,
    REG_TRIG_OFF = 2'd1,
    REG_SEED     = 2'd2
  } reg_idx_t;

  // One step of the xorshift32 generator.
  function automatic word_t xs_step(input word_t x);
    word_t a;
    word_t b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

// ===== sv/random_subset_cv_router_core.sv =====
// ----------------------------------------------------------------------------
// random_subset_cv_router_core: sample-and-hold CV router with random subsets
// On each trigger a random subset of the eligible channels is made active and
// the CV is sampled and held for them.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries one control-rate sample and
// produces exactly one result transfer. A trigger is a rising edge of a Schmitt
// trigger on the trigger voltage (thresholds set by the on and off registers)
// or a rising edge of the button. On a trigger, floor(count * chance / 256) of
// the first count channels are picked at random through a fixed shuffle with
// one swap per channel, driven by a xorshift32 generator, and the CV is sampled;
// the active mask and held CV stay until the next trigger. The block takes one
// sample every clock cycle while the result is not stalled: a sample is held in
// the input register, the whole trigger, shuffle and selection path is
// evaluated combinationally from it, and the result is registered. A stalled
// result holds both stages; nothing else limits the rate. Writing the seed
// register reloads the generator (a zero seed loads 1). The configuration port
// is always ready; it must be written only while idle (not enforced here).
// ----------------------------------------------------------------------------
module random_subset_cv_router_core #(
  parameter int CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input sample channel
  input  logic               in_valid,
  output logic               in_stall,
  input  rscr_pkg::level_t   in_trigger_level,
  input  logic               in_button_level,
  input  rscr_pkg::level_t   in_cv_level,
  input  rscr_pkg::count_t   in_select_count,
  input  rscr_pkg::chance_t  in_chance,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output rscr_pkg::mask_t    out_active_mask,
  output rscr_pkg::level_t   out_held_cv,
  output rscr_pkg::mask_t    out_eligible_mask,
  // Configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  rscr_pkg::cfg_idx_t cfg_index,
  input  rscr_pkg::word_t    cfg_data
);
  import rscr_pkg::*;

  // Bits of a channel number, and of the product used to scale a random word.
  localparam int IW = $clog2(CHANNELS);
  localparam int PW = 33 + IW;

  // Input register stage.
  logic    in_vld_r;
  level_t  trig_r;
  logic    btn_r;
  level_t  cv_r;
  count_t  cnt_r;
  chance_t chance_r;

  // Configuration and persistent state.
  level_t              on_r;
  level_t              off_r;
  word_t               rng_r;
  word_t               rng_nxt;
  logic                sch_r;
  logic                sch_nxt;
  logic                btn_prev_r;
  logic [CHANNELS-1:0] active_r;
  logic [CHANNELS-1:0] active_nxt;
  level_t              held_r;

  // Result register stage.
  logic   out_valid_r;
  mask_t  out_active_r;
  level_t out_held_r;
  mask_t  out_elig_r;

  // Handshake. Both stages move together whenever the result register is
  // free or being drained this cycle.
  logic adv;
  logic take_in;
  logic fire;
  logic trig_fire;
  logic cfg_wr;

  assign adv     = !out_valid_r || !out_stall;
  assign in_stall = in_vld_r && !adv;
  assign take_in = in_valid && !in_stall;
  assign fire    = in_vld_r && adv;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Count and chance saturation, target size of the subset.
  logic [CNT_W-1:0]    cnt_sat;
  chance_t             chance_sat;
  logic [13:0]         target_prod;
  logic [CNT_W-1:0]    target;
  logic [CHANNELS-1:0] elig;

  always_comb begin
    cnt_sat = ({1'b0, cnt_r} > CNT_W'(CHANNELS)) ? CNT_W'(CHANNELS) : {1'b0, cnt_r};
    chance_sat = (chance_r > CHANCE_MAX) ? CHANCE_MAX : chance_r;
    // At most 16 * 256, which needs bit 12.
    target_prod = 14'(cnt_sat) * 14'(chance_sat);
    target = target_prod[12:8];
    for (int i = 0; i < CHANNELS; i++) begin
      elig[i] = CNT_W'(i) < cnt_sat;
    end
  end

  // Trigger detection: Schmitt trigger with hysteresis, plus button edge.
  logic sch_edge;
  logic btn_edge;

  always_comb begin
    sch_nxt  = sch_r;
    sch_edge = 1'b0;
    if (sch_r) begin
      if (trig_r <= off_r) begin
        sch_nxt = 1'b0;
      end
    end else if (trig_r >= on_r) begin
      sch_nxt  = 1'b1;
      sch_edge = 1'b1;
    end
    btn_edge = btn_r && !btn_prev_r;
  end

  assign trig_fire = fire && (sch_edge || btn_edge);

  // Generator chain: one xorshift step per swap, each scaled to a channel.
  word_t         rng_chain [CHANNELS+1];
  logic [IW-1:0] swap_j    [CHANNELS];

  always_comb begin : rng_walk
    logic [PW-1:0] prod;
    rng_chain[0] = rng_r;
    for (int k = 0; k < CHANNELS; k++) begin
      rng_chain[k+1] = xs_step(rng_chain[k]);
      prod           = PW'(rng_chain[k+1]) * PW'(CHANNELS);
      // The product's upper part is always below CHANNELS.
      swap_j[k]      = prod[32 +: IW];
    end
  end

  // Shuffle of the channel list. A slot is eligible exactly when the
  // channel it holds is below the count, so only channel numbers move.
  logic [IW-1:0] perm [CHANNELS];

  always_comb begin : shuffle
    logic [IW-1:0] tmp;
    for (int i = 0; i < CHANNELS; i++) begin
      perm[i] = IW'(i);
    end
    for (int k = 0; k < CHANNELS; k++) begin
      tmp               = perm[k];
      perm[k]           = perm[swap_j[k]];
      perm[swap_j[k]]   = tmp;
    end
  end

  // Take the first target eligible channels in shuffled order.
  always_comb begin : pick
    logic [CNT_W-1:0] taken;
    taken      = '0;
    active_nxt = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if ((CNT_W'(perm[i]) < cnt_sat) && (taken < target)) begin
        active_nxt[perm[i]] = 1'b1;
        taken               = taken + CNT_W'(1);
      end
    end
  end

  // The generator reloads on a seed write and otherwise advances on every trigger.
  always_comb begin
    rng_nxt = rng_r;
    if (cfg_wr && (reg_idx_t'(cfg_index) == REG_SEED)) begin
      rng_nxt = (cfg_data == '0) ? SEED_RST : cfg_data;
    end else if (trig_fire) begin
      rng_nxt = rng_chain[CHANNELS];
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
    if (take_in) begin
      trig_r   <= in_trigger_level;
      btn_r    <= in_button_level;
      cv_r     <= in_cv_level;
      cnt_r    <= in_select_count;
      chance_r <= in_chance;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r  <= TRIG_ON_RST;
      off_r <= TRIG_OFF_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TRIG_ON:  on_r  <= cfg_data[15:0];
        REG_TRIG_OFF: off_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Router state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r      <= SEED_RST;
      sch_r      <= 1'b0;
      btn_prev_r <= 1'b0;
      active_r   <= '0;
      held_r     <= '0;
    end else begin
      rng_r <= rng_nxt;
      if (fire) begin
        sch_r      <= sch_nxt;
        btn_prev_r <= btn_r;
      end
      if (trig_fire) begin
        active_r <= active_nxt;
        held_r   <= cv_r;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_vld_r;
    end
    if (fire) begin
      out_active_r <= MASK_W'(trig_fire ? active_nxt : active_r);
      out_held_r   <= trig_fire ? cv_r : held_r;
      out_elig_r   <= MASK_W'(elig);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_active_mask   = out_active_r;
  assign out_held_cv       = out_held_r;
  assign out_eligible_mask = out_elig_r;

  // A triggered selection activates exactly the target number of channels.
  a_target_count: assert property (@(posedge clk) disable iff (!rst_n)
    trig_fire |-> ($countones(active_nxt) == int'(target)))
    else $error("selected channel count differs from target");

  // A triggered selection activates only eligible channels.
  a_subset_eligible: assert property (@(posedge clk) disable iff (!rst_n)
    trig_fire |-> ((active_nxt & ~elig) == '0))
    else $error("ineligible channel selected");

  // The generator state never reaches the stuck zero state.
  a_rng_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    rng_r != '0)
    else $error("generator state is zero");

  // The held CV changes only after a trigger.
  a_held_on_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(trig_fire)) |-> $stable(held_r))
    else $error("held CV changed without a trigger");

endmodule
